// ----- rtl/hdh_pkg.sv -----
`timescale 1ns / 1ps

package hdh_pkg;

  localparam int PMT_BITS    = 12;
  localparam int MPPC_BITS   = 64;
  localparam int TDC_BITS    = 31;
  localparam int ACTION_W    = 2;
  localparam int RC_W        = 4;
  localparam int RB_W        = 7;
  localparam int BIN_COUNT_W = 32;
  localparam int FILLS_W     = 5;
  localparam int WIN_W       = 11;
  localparam int TIME_W      = 32;
  localparam int IDX_W       = TIME_W + 3;

  localparam int APB_ADDR_W  = 2;
  localparam int APB_DATA_W  = 32;
  localparam logic [APB_ADDR_W-1:0] REG_WINDOW_LOW_ADDR = APB_ADDR_W'(0);
  localparam logic signed [WIN_W-1:0] WINDOW_LOW_RESET = -WIN_W'(20);

  localparam int PMT_CHANNELS_DEF = 12;
  localparam int NUM_BINS_DEF     = 70;
  localparam int COUNT_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF  = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_HIT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [PMT_BITS-1:0] pmt;
    logic                mppc;
    logic [TIME_W-1:0]   t;
    logic [RC_W-1:0]     rc;
    logic [RB_W-1:0]     rb;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

// ----- rtl/hdh_hit_if.sv -----
`timescale 1ns / 1ps

interface hdh_hit_if;
  import hdh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [PMT_BITS-1:0]  pmt_hits;
  logic [MPPC_BITS-1:0] mppc_hits;
  logic [TDC_BITS-1:0]  tdc_count;
  logic [TDC_BITS-1:0]  sync_offset;
  logic [RC_W-1:0]      read_channel;
  logic [RB_W-1:0]      read_bin;

  modport source (
    output valid, action, pmt_hits, mppc_hits, tdc_count, sync_offset, read_channel,
           read_bin,
    input  ready
  );

  modport sink (
    input  valid, action, pmt_hits, mppc_hits, tdc_count, sync_offset, read_channel,
           read_bin,
    output ready
  );
endinterface

// ----- rtl/hdh_res_if.sv -----
`timescale 1ns / 1ps

interface hdh_res_if;
  import hdh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [BIN_COUNT_W-1:0] bin_count;
  logic [FILLS_W-1:0]     fills_made;

  modport source (output valid, bin_count, fills_made, input ready);
  modport sink (input valid, bin_count, fills_made, output ready);
endinterface

// ----- rtl/hdh_ram.sv -----
`timescale 1ns / 1ps

module hdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 840
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hdh_front.sv -----
`timescale 1ns / 1ps

module hdh_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  hdh_hit_if.sink                                 hit_i,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [hdh_pkg::APB_ADDR_W-1:0]          paddr,
  input  logic [hdh_pkg::APB_DATA_W-1:0]          pwdata,
  output logic [hdh_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                    pready,
  output hdh_pkg::cmd_t                           cmd_o,
  output logic                                    cmd_valid_o,
  input  logic                                    cmd_ready_i,
  input  hdh_pkg::back_status_t                   status_i,
  output logic signed [hdh_pkg::WIN_W-1:0]        window_low_o
);
  import hdh_pkg::*;

  logic signed [WIN_W-1:0] win_q;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_WINDOW_LOW_ADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WINDOW_LOW_RESET;
    end else if (cfg_wr) begin
      win_q <= $signed(pwdata[WIN_W-1:0]);
    end
  end

  assign prdata       = (paddr == REG_WINDOW_LOW_ADDR) ? APB_DATA_W'(win_q) : '0;
  assign window_low_o = win_q;

  // hold off traffic during the post-reset clearing pass
  assign hit_i.ready = cmd_ready_i && !status_i.init_busy;
  assign cmd_valid_o = hit_i.valid && !status_i.init_busy;

  always_comb begin
    cmd_o.action = action_e'(hit_i.action);
    cmd_o.pmt    = hit_i.pmt_hits;
    cmd_o.mppc   = |hit_i.mppc_hits;
    cmd_o.t      = TIME_W'(hit_i.tdc_count) + TIME_W'(hit_i.sync_offset);
    cmd_o.rc     = hit_i.read_channel;
    cmd_o.rb     = hit_i.read_bin;
  end

endmodule

// ----- rtl/hdh_fifo.sv -----
`timescale 1ns / 1ps

module hdh_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hdh_pkg::cmd_t data_i,
  output logic          ready_o,
  input  logic          pop_i,
  output hdh_pkg::cmd_t data_o,
  output logic          valid_o
);
  import hdh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/hdh_back.sv -----
`timescale 1ns / 1ps

module hdh_back #(
  parameter int PMT_CHANNELS = 12,
  parameter int NUM_BINS     = 70,
  parameter int COUNT_BITS   = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hdh_pkg::cmd_t                        cmd_i,
  input  logic                                 cmd_valid_i,
  output logic                                 cmd_pop_o,
  input  logic signed [hdh_pkg::WIN_W-1:0]     window_low_i,
  output hdh_pkg::back_status_t                status_o,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output logic [hdh_pkg::BIN_COUNT_W-1:0]      bin_count_o,
  output logic [hdh_pkg::FILLS_W-1:0]          fills_made_o
);
  import hdh_pkg::*;

  localparam int DEPTH  = PMT_CHANNELS * NUM_BINS;
  localparam int AW     = $clog2(DEPTH);
  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int CH_W   = (PMT_CHANNELS > 1) ? $clog2(PMT_CHANNELS) : 1;
  localparam int A_LAST = ((PMT_CHANNELS < PMT_BITS) ? PMT_CHANNELS : PMT_BITS) - 1;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_WR     = 4'd4;
  localparam logic [3:0] S_UPDATE = 4'd5;
  localparam logic [3:0] S_RADDR  = 4'd6;
  localparam logic [3:0] S_CLR    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]                state_q, state_d;
  cmd_t                      cmd_q, cmd_d;
  logic [CH_W-1:0]           ch_q, ch_d;
  logic [AW-1:0]             base_q, base_d;
  logic                      phase_b_q, phase_b_d;
  logic signed [IDX_W-2:0]   diff_a_q, diff_a_d;
  logic signed [IDX_W-2:0]   base_b_q, base_b_d;
  logic [FILLS_W-1:0]        fills_q, fills_d;
  logic [AW-1:0]             clr_q, clr_d;
  logic [AW-1:0]             wr_addr_q, wr_addr_d;
  logic                      rd_ok_q, rd_ok_d;
  logic                      res_valid_q, res_valid_d;
  logic [BIN_COUNT_W-1:0]    bin_q, bin_d;
  logic [FILLS_W-1:0]        res_fills_q, res_fills_d;
  logic [TIME_W-1:0]         pmt_latest_q [PMT_CHANNELS];
  logic [TIME_W-1:0]         mppc_latest_q;

  logic [PMT_CHANNELS-1:0]   pmt_mask;
  logic signed [IDX_W-1:0]   idx_a, idx_b, idx;
  logic                      in_win, slot_en, last_ch;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0]     ram_wdata, ram_rdata;
  logic [BIN_COUNT_W-1:0]    ram_cnt32;

  hdh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  if (PMT_CHANNELS >= PMT_BITS) begin : g_mask_ext
    assign pmt_mask = PMT_CHANNELS'(cmd_q.pmt);
  end else begin : g_mask_cut
    assign pmt_mask = cmd_q.pmt[PMT_CHANNELS-1:0];
  end

  if (COUNT_BITS >= BIN_COUNT_W) begin : g_cnt_cut
    assign ram_cnt32 = ram_rdata[BIN_COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign ram_cnt32 = BIN_COUNT_W'(ram_rdata);
  end

  // bin index of the current slot
  assign idx_a   = IDX_W'(diff_a_q) - IDX_W'(window_low_i);
  assign idx_b   = $signed({3'b000, pmt_latest_q[ch_q]}) - IDX_W'(base_b_q);
  assign idx     = phase_b_q ? idx_b : idx_a;
  assign in_win  = !idx[IDX_W-1] && (idx[IDX_W-2:0] < (IDX_W-1)'(NUM_BINS));
  assign slot_en = phase_b_q ? 1'b1 : pmt_mask[ch_q];
  assign last_ch = phase_b_q ? (ch_q == CH_W'(PMT_CHANNELS - 1)) : (ch_q == CH_W'(A_LAST));

  assign status_o.init_busy = (state_q == S_INIT);
  assign res_valid_o        = res_valid_q;
  assign bin_count_o        = bin_q;
  assign fills_made_o       = res_fills_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    ch_d        = ch_q;
    base_d      = base_q;
    phase_b_d   = phase_b_q;
    diff_a_d    = diff_a_q;
    base_b_d    = base_b_q;
    fills_d     = fills_q;
    clr_d       = clr_q;
    wr_addr_d   = wr_addr_q;
    rd_ok_d     = rd_ok_q;
    res_valid_d = res_valid_q && !res_ready_i;
    bin_d       = bin_q;
    res_fills_d = res_fills_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = '0;
    ram_raddr   = base_q + AW'(idx[BIN_W-1:0]);

    case (state_q)
      S_INIT, S_CLR: begin
        ram_we = 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          fills_d   = '0;
          rd_ok_d   = 1'b0;
          clr_d     = '0;
          case (cmd_i.action)
            ACT_HIT:   state_d = S_SETUP;
            ACT_READ:  state_d = S_RADDR;
            ACT_CLEAR: state_d = S_CLR;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_SETUP: begin
        diff_a_d  = $signed({2'b00, cmd_q.t}) - $signed({2'b00, mppc_latest_q});
        base_b_d  = $signed({2'b00, cmd_q.t}) + (IDX_W-1)'(window_low_i);
        phase_b_d = 1'b0;
        ch_d      = '0;
        base_d    = '0;
        state_d   = S_SCAN;
      end
      S_SCAN, S_WR: begin
        if (state_q == S_SCAN && slot_en && in_win) begin
          ram_re    = 1'b1;
          wr_addr_d = ram_raddr;
          state_d   = S_WR;
        end else begin
          if (state_q == S_WR) begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_q;
            ram_wdata = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
            fills_d   = (&fills_q) ? fills_q : fills_q + FILLS_W'(1);
          end
          if (last_ch) begin
            if (!phase_b_q && cmd_q.mppc) begin
              phase_b_d = 1'b1;
              ch_d      = '0;
              base_d    = '0;
              state_d   = S_SCAN;
            end else begin
              state_d = S_UPDATE;
            end
          end else begin
            ch_d    = ch_q + CH_W'(1);
            base_d  = base_q + AW'(NUM_BINS);
            state_d = S_SCAN;
          end
        end
      end
      S_UPDATE: begin
        state_d = S_DONE;
      end
      S_RADDR: begin
        rd_ok_d   = (32'(cmd_q.rc) < PMT_CHANNELS) && (32'(cmd_q.rb) < NUM_BINS);
        ram_re    = 1'b1;
        ram_raddr = AW'(32'(cmd_q.rc) * NUM_BINS + 32'(cmd_q.rb));
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!res_valid_q || res_ready_i) begin
          res_valid_d = 1'b1;
          bin_d       = (cmd_q.action == ACT_READ && rd_ok_q) ? ram_cnt32 : '0;
          res_fills_d = fills_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      ch_q        <= '0;
      phase_b_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
      ch_q        <= ch_d;
      phase_b_q   <= phase_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    base_q      <= base_d;
    diff_a_q    <= diff_a_d;
    base_b_q    <= base_b_d;
    fills_q     <= fills_d;
    wr_addr_q   <= wr_addr_d;
    rd_ok_q     <= rd_ok_d;
    bin_q       <= bin_d;
    res_fills_q <= res_fills_d;
  end

  // latest hit times, written after all fills of an item
  always_ff @(posedge clk_i) begin
    if (state_q == S_INIT || state_q == S_CLR) begin
      mppc_latest_q <= '0;
    end else if (state_q == S_UPDATE && cmd_q.mppc) begin
      mppc_latest_q <= cmd_q.t;
    end
  end

  for (genvar c = 0; c < PMT_CHANNELS; c++) begin : g_latest
    always_ff @(posedge clk_i) begin
      if (state_q == S_INIT || state_q == S_CLR) begin
        pmt_latest_q[c] <= '0;
      end else if (state_q == S_UPDATE && pmt_mask[c]) begin
        pmt_latest_q[c] <= cmd_q.t;
      end
    end
  end

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_INIT || state_q == S_CLR || state_q == S_WR))
    else $error("histogram written outside clear or increment");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE))
    else $error("queue popped while busy");

  a_phase_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && phase_b_q) |-> cmd_q.mppc)
    else $error("mppc pass without mppc hit");

  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside done state");

  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> (ram_wdata != '0))
    else $error("bin count wrapped");

endmodule

// ----- rtl/hit_time_difference_histogrammer.sv -----
`timescale 1ns / 1ps

// Hit time difference histogrammer.
// hit_i carries one transaction per command: action selects a hit (fill), a
// single-bin read, a clear, or a no-op. res_o returns exactly one transaction
// per command: bin_count for a read, fills_made for a hit, zeros otherwise.
// window_low is written over the APB port at address 0 (pready always high).
// A hit scans min(PMT_CHANNELS,12) channels, plus PMT_CHANNELS more when any
// MPPC fired, with an extra write step per in-window increment; each
// increment is a read-modify-write on the single-port-pair bin RAM. A read
// goes from S_RADDR to S_DONE; a clear zeroes all PMT_CHANNELS*NUM_BINS
// bins, one bin per cycle. The back end runs one command at a time and
// takes a queued one only from idle. Commands queue in a QUEUE_DEPTH-entry
// buffer, so hit_i keeps accepting while the back end works or while a
// finished result waits on res_o. After reset all PMT_CHANNELS*NUM_BINS bins
// (840 with defaults) are swept to zero, one bin per cycle; hit_i.ready is low
// during that pass, APB writes are taken as usual. A stalled res_o holds
// its transaction; the back end waits once its next result is ready, and
// hit_i.ready drops when the queue is full.
module hit_time_difference_histogrammer #(
  parameter int PMT_CHANNELS = hdh_pkg::PMT_CHANNELS_DEF,
  parameter int NUM_BINS     = hdh_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS   = hdh_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH  = hdh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hdh_hit_if.sink                        hit_i,
  hdh_res_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hdh_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hdh_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hdh_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import hdh_pkg::*;

  cmd_t                    front_cmd, queue_cmd;
  logic                    front_valid, queue_ready, queue_valid, queue_pop;
  back_status_t            back_status;
  logic signed [WIN_W-1:0] window_low;

  hdh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hit_i        (hit_i),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cmd_o        (front_cmd),
    .cmd_valid_o  (front_valid),
    .cmd_ready_i  (queue_ready),
    .status_i     (back_status),
    .window_low_o (window_low)
  );

  hdh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cmd),
    .ready_o (queue_ready),
    .pop_i   (queue_pop),
    .data_o  (queue_cmd),
    .valid_o (queue_valid)
  );

  hdh_back #(
    .PMT_CHANNELS (PMT_CHANNELS),
    .NUM_BINS     (NUM_BINS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (queue_cmd),
    .cmd_valid_i  (queue_valid),
    .cmd_pop_o    (queue_pop),
    .window_low_i (window_low),
    .status_o     (back_status),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .bin_count_o  (res_o.bin_count),
    .fills_made_o (res_o.fills_made)
  );

endmodule

// ----- bench/tb_hit_time_difference_histogrammer.sv -----
`timescale 1ns / 1ps

module tb_hit_time_difference_histogrammer;
  import hdh_pkg::*;

  localparam int     NCH       = PMT_CHANNELS_DEF;
  localparam int     NBINS     = NUM_BINS_DEF;
  localparam int     NCELLS    = NCH * NBINS;
  localparam int     FILLS_CAP = 31;
  localparam longint T_MAX     = 64'd4294967294;
  localparam longint TDC_MAX   = 64'd2147483647;

  typedef struct {
    action_e              action;
    logic [PMT_BITS-1:0]  pmt;
    logic [MPPC_BITS-1:0] mppc;
    logic [TDC_BITS-1:0]  tdc;
    logic [TDC_BITS-1:0]  sync;
    logic [RC_W-1:0]      rc;
    logic [RB_W-1:0]      rb;
  } hit_cmd_t;

  typedef struct {
    logic [BIN_COUNT_W-1:0] bin_count;
    logic [FILLS_W-1:0]     fills_made;
  } hist_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  hdh_hit_if hit_bus ();
  hdh_res_if res_bus ();

  hit_time_difference_histogrammer u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .hit_i   (hit_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // histogram shadow state
  logic [COUNT_BITS_DEF-1:0] hist_bins [NCELLS];
  logic [TIME_W-1:0]         pmt_last_t [NCH];
  logic [TIME_W-1:0]         mppc_last_t;
  logic signed [WIN_W-1:0]   win_low;
  hist_reply_t               replies_q [$];
  int                        fail_count;
  int                        burst_left;

  function automatic void clear_hist();
    foreach (hist_bins[i]) hist_bins[i] = '0;
    foreach (pmt_last_t[i]) pmt_last_t[i] = '0;
    mppc_last_t = '0;
  endfunction

  function automatic int bump_bin(int ch, longint d);
    longint idx;
    idx = d - longint'(win_low);
    if (idx < 0 || idx >= NBINS) return 0;
    if (hist_bins[ch*NBINS + int'(idx)] != '1) begin
      hist_bins[ch*NBINS + int'(idx)] = hist_bins[ch*NBINS + int'(idx)] + 1'b1;
    end
    return 1;
  endfunction

  function automatic void histogram_step(hit_cmd_t c);
    hist_reply_t       r;
    logic [TIME_W-1:0] t;
    int                fills;
    int                ch;
    r.bin_count  = '0;
    r.fills_made = '0;
    fills        = 0;
    case (c.action)
      ACT_HIT: begin
        t = TIME_W'(c.tdc) + TIME_W'(c.sync);
        for (ch = 0; ch < NCH; ch++) begin
          if (c.pmt[ch]) fills += bump_bin(ch, longint'(t) - longint'(mppc_last_t));
        end
        if (|c.mppc) begin
          for (ch = 0; ch < NCH; ch++) begin
            fills += bump_bin(ch, longint'(pmt_last_t[ch]) - longint'(t));
          end
        end
        for (ch = 0; ch < NCH; ch++) begin
          if (c.pmt[ch]) pmt_last_t[ch] = t;
        end
        if (|c.mppc) mppc_last_t = t;
        r.fills_made = FILLS_W'((fills > FILLS_CAP) ? FILLS_CAP : fills);
      end
      ACT_READ: begin
        if (c.rc < NCH && c.rb < NBINS) begin
          r.bin_count = BIN_COUNT_W'(hist_bins[c.rc*NBINS + c.rb]);
        end
      end
      ACT_CLEAR: clear_hist();
      default: ;
    endcase
    replies_q.push_back(r);
  endfunction

  function automatic hit_cmd_t mk_cmd(action_e a, logic [PMT_BITS-1:0] pmt,
                                      logic [MPPC_BITS-1:0] mppc, longint t,
                                      logic [RC_W-1:0] rc, logic [RB_W-1:0] rb);
    hit_cmd_t c;
    longint   lo;
    longint   hi;
    longint   tdc;
    c.action = a;
    c.pmt    = pmt;
    c.mppc   = mppc;
    c.rc     = rc;
    c.rb     = rb;
    lo       = (t > TDC_MAX) ? t - TDC_MAX : 0;
    hi       = (t < TDC_MAX) ? t : TDC_MAX;
    tdc      = lo + longint'($urandom_range(32'(hi - lo), 0));
    c.tdc    = TDC_BITS'(tdc);
    c.sync   = TDC_BITS'(t - tdc);
    return c;
  endfunction

  function automatic longint rand_time();
    return longint'($urandom_range(32'hFFFF_FFFE, 0));
  endfunction

  function automatic logic [PMT_BITS-1:0] rand_pmt();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return PMT_BITS'(1) << $urandom_range(0, PMT_BITS-1);
      2:       return '1;
      default: return PMT_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [MPPC_BITS-1:0] rand_mppc();
    case ($urandom_range(0, 4))
      0, 1:    return '0;
      2:       return MPPC_BITS'(1) << $urandom_range(0, MPPC_BITS-1);
      3:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic hit_cmd_t mk_hit(logic [PMT_BITS-1:0] pmt, logic [MPPC_BITS-1:0] mppc,
                                      longint t);
    return mk_cmd(ACT_HIT, pmt, mppc, t, RC_W'($urandom), RB_W'($urandom));
  endfunction

  function automatic hit_cmd_t mk_read(logic [RC_W-1:0] rc, logic [RB_W-1:0] rb);
    return mk_cmd(ACT_READ, rand_pmt(), rand_mppc(), rand_time(), rc, rb);
  endfunction

  // hits mostly land near the last PMT/MPPC times so differences fall in the window
  function automatic hit_cmd_t rand_cmd();
    int     pick;
    int     ch;
    int     off;
    int     k;
    int     idx;
    longint t;
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      off = int'($urandom_range(0, 75)) - 3;
      if ($urandom_range(0, 1) == 1) begin
        t = longint'(mppc_last_t) + longint'(win_low) + off;
      end else begin
        ch = $urandom_range(0, NCH-1);
        t  = longint'(pmt_last_t[ch]) - longint'(win_low) - off;
      end
      if (t < 0) t = -t;
      if (t > T_MAX) t = 2*T_MAX - t;
      return mk_hit(rand_pmt(), rand_mppc(), t);
    end
    if (pick < 70) return mk_hit(rand_pmt(), rand_mppc(), rand_time());
    if (pick < 90) begin
      if ($urandom_range(0, 6) == 0) begin
        return mk_read(RC_W'($urandom_range(0, 15)), RB_W'($urandom_range(0, 127)));
      end
      idx = $urandom_range(0, NCELLS-1);
      if ($urandom_range(0, 1) == 1) begin
        for (k = 0; k < NCELLS && hist_bins[idx] == '0; k++) idx = (idx + 1) % NCELLS;
      end
      return mk_read(RC_W'(idx / NBINS), RB_W'(idx % NBINS));
    end
    if (pick < 95) return mk_cmd(ACT_NOP, rand_pmt(), rand_mppc(), rand_time(),
                                 RC_W'($urandom), RB_W'($urandom));
    if (pick < 97) return mk_cmd(ACT_CLEAR, rand_pmt(), rand_mppc(), rand_time(),
                                 RC_W'($urandom), RB_W'($urandom));
    return mk_hit(rand_pmt(), '0, rand_time());
  endfunction

  task automatic send_cmd(hit_cmd_t c);
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) begin
        hit_bus.valid = 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4))
          @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    hit_bus.valid        = 1'b1;
    hit_bus.action       = c.action;
    hit_bus.pmt_hits     = c.pmt;
    hit_bus.mppc_hits    = c.mppc;
    hit_bus.tdc_count    = c.tdc;
    hit_bus.sync_offset  = c.sync;
    hit_bus.read_channel = c.rc;
    hit_bus.read_bin     = c.rb;
    @(posedge clk);
    while (!hit_bus.ready) @(posedge clk);
    histogram_step(c);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    hit_bus.valid = 1'b0;
    while (replies_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = REG_WINDOW_LOW_ADDR;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_window();
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[WIN_W-1:0] !== win_low) begin
      $error("window_low mismatch: expected %0d, actual %0d", win_low,
             $signed(rd[WIN_W-1:0]));
      fail_count++;
    end
  endtask

  task automatic set_window(logic signed [WIN_W-1:0] v);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b1, APB_DATA_W'(v), rd);
    win_low = v;
    check_window();
  endtask

  task automatic test_reset_state();
    check_window();
    send_cmd(mk_read(0, 0));
    send_cmd(mk_read(RC_W'(NCH-1), RB_W'(NBINS-1)));
    send_cmd(mk_cmd(ACT_NOP, '1, '1, T_MAX, '1, '1));
  endtask

  // latest times start at zero and are histogrammed as-is
  task automatic test_first_hits();
    send_cmd(mk_hit(12'h001, '0, 5));
    send_cmd(mk_hit('0, 64'h8000_0000_0000_0000, 10));
    send_cmd(mk_read(0, 25));
    send_cmd(mk_read(0, 15));
    send_cmd(mk_read(5, 10));
  endtask

  task automatic test_field_extremes();
    send_cmd(mk_hit('1, '1, T_MAX));
    send_cmd(mk_hit('1, '0, T_MAX));
    send_cmd(mk_hit('0, '0, 0));
    send_cmd(mk_read(RC_W'(NCH), 0));
    send_cmd(mk_read('1, '1));
    send_cmd(mk_read(0, RB_W'(NBINS)));
    send_cmd(mk_read(RC_W'(NCH-1), 20));
    send_cmd(mk_cmd(ACT_CLEAR, '0, '0, 0, '0, '0));
    send_cmd(mk_read(RC_W'(NCH-1), 20));
  endtask

  task automatic test_window_edges();
    wait_drain();
    set_window(5);
    send_cmd(mk_cmd(ACT_CLEAR, '1, '1, T_MAX, '1, '1));
    send_cmd(mk_hit(12'h001, '0, 4));
    send_cmd(mk_hit(12'h002, '0, 5));
    send_cmd(mk_hit(12'h004, '0, 74));
    send_cmd(mk_hit(12'h008, '0, 75));
    send_cmd(mk_read(1, 0));
    send_cmd(mk_read(2, RB_W'(NBINS-1)));
    wait_drain();
    // clear must leave window_low alone
    check_window();
  endtask

  task automatic test_random_traffic();
    int wins [6];
    int p;
    int i;
    wins = '{-1024, 1023, -20, 0, 0, 0};
    for (p = 0; p < 6; p++) begin
      if (p >= 4) wins[p] = int'($urandom_range(0, 2047)) - 1024;
      wait_drain();
      set_window(WIN_W'(wins[p]));
      for (i = 0; i < 280; i++) begin
        if (p == 2 && i == 140) wait_drain();
        send_cmd(rand_cmd());
      end
    end
  endtask

  always @(posedge clk) begin : check_replies
    hist_reply_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (replies_q.size() == 0) begin
        $error("unexpected transaction: bin_count %0d, fills_made %0d",
               res_bus.bin_count, res_bus.fills_made);
        fail_count++;
      end else begin
        want = replies_q.pop_front();
        if (res_bus.bin_count !== want.bin_count) begin
          $error("bin_count mismatch: expected %0d, actual %0d",
                 want.bin_count, res_bus.bin_count);
          fail_count++;
        end
        if (res_bus.fills_made !== want.fills_made) begin
          $error("fills_made mismatch: expected %0d, actual %0d",
                 want.fills_made, res_bus.fills_made);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int mode;
    int span;
    int n;
    res_bus.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      for (n = 0; n < span; n++) begin
        @(negedge clk);
        case (mode)
          0:       res_bus.ready = 1'b1;
          1:       res_bus.ready = ($urandom_range(0, 1) == 1);
          2:       res_bus.ready = (n % 4 != 3);
          default: res_bus.ready = ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL hit_time_difference_histogrammer");
    $finish;
  end

  initial begin
    hit_bus.valid        = 1'b0;
    hit_bus.action       = ACT_NOP;
    hit_bus.pmt_hits     = '0;
    hit_bus.mppc_hits    = '0;
    hit_bus.tdc_count    = '0;
    hit_bus.sync_offset  = '0;
    hit_bus.read_channel = '0;
    hit_bus.read_bin     = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    fail_count           = 0;
    burst_left           = 0;
    clear_hist();
    win_low = WINDOW_LOW_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_first_hits();
    test_field_extremes();
    test_window_edges();
    test_random_traffic();

    wait_drain();
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS hit_time_difference_histogrammer");
    end else begin
      $display("FAIL hit_time_difference_histogrammer");
    end
    $finish;
  end

endmodule
